### rtl/core/i2cme_pkg.sv
package i2cme_pkg;

  localparam int unsigned TickWidth  = 16;
  localparam int unsigned PhaseWidth = 5;
  localparam int unsigned CfgWidth   = 16;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WACK  = 3'd4
  } cmd_e;

  typedef enum logic {
    REG_PHASE_TICKS = 1'b0,
    REG_ACK_WAIT    = 1'b1
  } reg_idx_e;

  localparam logic [TickWidth-1:0] PhaseTicksReset = TickWidth'(4);
  localparam logic [TickWidth-1:0] AckWaitReset    = TickWidth'(10);

  // Last phase index of each command sequence.
  localparam logic [PhaseWidth-1:0] LastStart = PhaseWidth'(3);
  localparam logic [PhaseWidth-1:0] LastStop  = PhaseWidth'(2);
  localparam logic [PhaseWidth-1:0] LastWrite = PhaseWidth'(24);
  localparam logic [PhaseWidth-1:0] LastRead  = PhaseWidth'(20);
  localparam logic [PhaseWidth-1:0] LastWack  = PhaseWidth'(2);

  typedef struct packed {
    logic       sda_in;
    logic       send_nack;
    logic [7:0] tx_byte;
    logic [2:0] func;
    logic       cmd_valid;
  } tick_t;

  typedef struct packed {
    logic       ack_status;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } result_t;

  // Phase index modulo three, by multiplication with a reciprocal.
  // Exact for every five bit phase index.
  function automatic logic [1:0] phase_mod3(input logic [PhaseWidth-1:0] p);
    logic [PhaseWidth+3:0] prod;
    logic [PhaseWidth-1:0] quot;
    logic [PhaseWidth+1:0] back;
    prod = {4'd0, p} * (PhaseWidth+4)'(11);
    quot = PhaseWidth'(prod[PhaseWidth+4-1:5]);
    back = {2'd0, quot} + {1'b0, quot, 1'b0};
    return 2'({2'd0, p} - back);
  endfunction

endpackage

### rtl/core/i2c_master_byte_engine.sv
// I2C master byte engine, stepped by time ticks.
// Each transaction on the slave stream is one tick: it may carry a command
// (start, stop, write byte, read byte, wait for acknowledge) and always carries
// the sampled SDA level. Each tick gives exactly one transaction on the master
// stream with the SCL/SDA open-drain levels, busy, a done pulse, the last read
// byte and the last acknowledge seen. A command offered while busy is dropped.
// Bus phases last phase_ticks ticks; the acknowledge slot after a write lasts
// ack_wait_ticks ticks. A zero register value counts as one tick.
// A tick goes through the input register, then sequencer logic into the result
// register. Throughput is one tick per clock cycle while m_axis_tready does not
// stall. The sequencer advances only when the result register is empty or being
// drained, so a stall on m_axis_tready holds the pending result and backs up to
// s_axis_tready without losing any tick. Reset releases both lines high, clears
// the sequencer, rx byte and ack status, and loads phase_ticks with 4 and
// ack_wait_ticks with 10. The user writes registers via cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while the engine is idle; the block does not enforce this.
module i2c_master_byte_engine import i2cme_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] tx_byte, [8] send_nack, [9] sda_in, [15:10] zero
  input  logic [15:0]         s_axis_tdata,
  // [0] cmd_valid, [3:1] func
  input  logic [3:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] ack_status, [15:13] zero
  output logic [15:0]         m_axis_tdata
);

  tick_t   tick_in, tick_held;
  result_t res_next, res_out;
  logic    held_valid, out_can_load, step;

  assign tick_in.cmd_valid = s_axis_tuser[0];
  assign tick_in.func      = s_axis_tuser[3:1];
  assign tick_in.tx_byte   = s_axis_tdata[7:0];
  assign tick_in.send_nack = s_axis_tdata[8];
  assign tick_in.sda_in    = s_axis_tdata[9];

  assign step = held_valid && out_can_load;

  i2cme_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .tick_i  (tick_in),
    .valid_o (held_valid),
    .take_i  (step),
    .tick_o  (tick_held)
  );

  i2cme_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .tick_i      (tick_held),
    .res_o       (res_next)
  );

  i2cme_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .res_i      (res_next),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (res_out)
  );

  assign m_axis_tdata = {3'd0, res_out};

  // A finishing tick never reports the engine as still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done reported together with busy");

  // With the result register empty the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // A held tick with room for its result is consumed in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("held tick did not produce a result");

endmodule

### rtl/core/i2cme_in_stage.sv
module i2cme_in_stage import i2cme_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  tick_t tick_i,
  output logic  valid_o,
  input  logic  take_i,
  output tick_t tick_o
);

  logic  valid_q, valid_d;
  tick_t tick_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tick_q <= tick_i;
    end
  end

  assign valid_o = valid_q;
  assign tick_o  = tick_q;

endmodule

### rtl/core/i2cme_seq.sv
module i2cme_seq import i2cme_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                step_i,
  input  tick_t               tick_i,
  output result_t             res_o
);

  logic [TickWidth-1:0]  phase_ticks_q, ack_wait_q;
  logic [2:0]            cmd_q, cmd_d;
  logic [PhaseWidth-1:0] phase_q, phase_d;
  logic [TickWidth-1:0]  tick_q, tick_d;
  logic [7:0]            shift_q, shift_d;
  logic                  nack_q, nack_d;
  logic                  scl_q, scl_d, sda_q, sda_d;
  logic                  ack_q, ack_d;
  logic                  run_q, run_d;
  logic [7:0]            rx_q, rx_d;
  logic                  done;

  logic                  start;
  logic [PhaseWidth-1:0] ph;
  logic [TickWidth-1:0]  tk, per, dur;
  logic [PhaseWidth-1:0] last;
  logic [1:0]            slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
      ack_wait_q    <= AckWaitReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PHASE_TICKS: phase_ticks_q <= cfg_wdata_i;
        REG_ACK_WAIT:    ack_wait_q    <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  always_comb begin
    start   = !run_q && tick_i.cmd_valid && (tick_i.func <= CMD_WACK);
    cmd_d   = start ? tick_i.func : cmd_q;
    ph      = start ? '0 : phase_q;
    tk      = start ? '0 : tick_q;
    nack_d  = start ? tick_i.send_nack : nack_q;
    shift_d = shift_q;
    if (start) begin
      shift_d = (tick_i.func == CMD_WRITE) ? tick_i.tx_byte : 8'd0;
    end
    run_d   = run_q || start;
    phase_d = ph;
    tick_d  = tk;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    slot    = phase_mod3(ph);

    unique case (cmd_e'(cmd_d))
      CMD_START: last = LastStart;
      CMD_STOP:  last = LastStop;
      CMD_WRITE: last = LastWrite;
      CMD_READ:  last = LastRead;
      default:   last = LastWack;
    endcase

    per = (cmd_d == CMD_WRITE && ph == LastWrite) ? ack_wait_q : phase_ticks_q;
    dur = (per == '0) ? TickWidth'(1) : per;

    if (run_d) begin
      // Line changes at the first tick of a phase.
      if (tk == '0) begin
        unique case (cmd_e'(cmd_d))
          CMD_START: begin
            if (ph == PhaseWidth'(0)) scl_d = 1'b1;
            else if (ph == PhaseWidth'(1)) sda_d = 1'b1;
            else if (ph == PhaseWidth'(2)) sda_d = 1'b0;
            else scl_d = 1'b0;
          end
          CMD_STOP: begin
            if (ph == PhaseWidth'(0)) begin
              scl_d = 1'b0;
              sda_d = 1'b0;
            end else if (ph == PhaseWidth'(1)) scl_d = 1'b1;
            else sda_d = 1'b1;
          end
          CMD_WRITE: begin
            if (ph >= LastWrite) scl_d = 1'b0;
            else if (slot == 2'd0) scl_d = 1'b0;
            else if (slot == 2'd1) begin
              sda_d   = shift_d[7];
              shift_d = {shift_d[6:0], 1'b0};
            end else scl_d = 1'b1;
          end
          CMD_READ: begin
            if (ph == PhaseWidth'(0)) scl_d = 1'b0;
            else if (ph <= PhaseWidth'(16)) begin
              if (ph[0]) begin
                if (ph == PhaseWidth'(1)) sda_d = 1'b1;
                scl_d = 1'b1;
              end else scl_d = 1'b0;
            end else if (ph == PhaseWidth'(17)) scl_d = 1'b0;
            else if (ph == PhaseWidth'(18)) sda_d = nack_d;
            else if (ph == PhaseWidth'(19)) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
          default: begin
            if (ph == PhaseWidth'(0)) sda_d = 1'b1;
            else if (ph == PhaseWidth'(1)) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
        endcase
      end

      if ({1'b0, tk} + (TickWidth+1)'(1) >= {1'b0, dur}) begin
        // SDA is sampled on the last tick of an SCL-high phase.
        if (cmd_d == CMD_READ && ph >= PhaseWidth'(1) && ph <= PhaseWidth'(16) && ph[0]) begin
          shift_d = {shift_d[6:0], tick_i.sda_in};
        end else if (cmd_d == CMD_WACK && ph == PhaseWidth'(1)) begin
          ack_d = tick_i.sda_in;
        end
        tick_d = '0;
        if (ph >= last) begin
          if (cmd_d == CMD_READ) begin
            sda_d = 1'b1;
            rx_d  = shift_d;
          end
          run_d   = 1'b0;
          phase_d = '0;
          done    = 1'b1;
        end else begin
          phase_d = ph + PhaseWidth'(1);
        end
      end else begin
        tick_d = tk + TickWidth'(1);
      end
    end

    res_o.scl_level  = scl_d;
    res_o.sda_level  = sda_d;
    res_o.busy_res   = run_d;
    res_o.done_res   = done;
    res_o.rx_byte    = rx_d;
    res_o.ack_status = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_START;
      phase_q <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
      run_q   <= 1'b0;
      rx_q    <= '0;
    end else if (step_i) begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      run_q   <= run_d;
      rx_q    <= rx_d;
    end
  end

endmodule

### rtl/core/i2cme_out_stage.sv
module i2cme_out_stage import i2cme_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    can_load_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
